/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helper macros for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds on every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error("%m failed");

// Check that an antecedent implies a consequent on the next edge.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m failed");

`endif

/* rtl/core/li_pkg.sv */
// ----------------------------------------------------------------------------
// li_pkg
// Types and constants shared by the line intersection block.
// ----------------------------------------------------------------------------
package li_pkg;

   localparam int COEF_WIDTH   = 16;
   localparam int RESULT_WIDTH = 32;
   localparam int FRAC_WIDTH   = 5;
   localparam int FRAC_MAX     = 16;
   // products and determinant
   localparam int PROD_WIDTH   = 2 * COEF_WIDTH;
   localparam int DET_WIDTH    = PROD_WIDTH + 1;
   // magnitude of det, numerators
   localparam int MAG_WIDTH    = DET_WIDTH;
   // dividend = |num| << FRAC_MAX
   localparam int DIVD_WIDTH   = MAG_WIDTH + FRAC_MAX;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_WIDTH   = 2;

   localparam logic [FRAC_WIDTH-1:0] FRAC_RESET = FRAC_WIDTH'(FRAC_MAX);
   localparam logic [0:0]            REG_FRACTION_BITS = 1'b0;

   typedef struct packed {
      logic signed [COEF_WIDTH-1:0] line_a_x_coef;
      logic signed [COEF_WIDTH-1:0] line_a_y_coef;
      logic signed [COEF_WIDTH-1:0] line_a_const;
      logic signed [COEF_WIDTH-1:0] line_b_x_coef;
      logic signed [COEF_WIDTH-1:0] line_b_y_coef;
      logic signed [COEF_WIDTH-1:0] line_b_const;
   } req_type;

   typedef struct packed {
      logic signed [RESULT_WIDTH-1:0] cross_x;
      logic signed [RESULT_WIDTH-1:0] cross_y;
      logic                           parallel;
      logic                           overflow;
   } rsp_type;

   // classified work handed from the front to the back
   typedef struct packed {
      logic [MAG_WIDTH-1:0]  det_mag;
      logic [MAG_WIDTH-1:0]  x_mag;
      logic [MAG_WIDTH-1:0]  y_mag;
      logic                  x_neg;
      logic                  y_neg;
      logic                  parallel;
      logic [FRAC_WIDTH-1:0] frac;
   } work_type;

endpackage

/* rtl/core/line_intersection.sv */
// ----------------------------------------------------------------------------
// line_intersection
// Intersection of two lines a*x + b*y + c = 0 by Cramer's rule.
// ----------------------------------------------------------------------------
// Takes one line pair per cycle while req_ready is high. The front forms
// the six products (one multiplier each) and the determinant in two
// stages, a four-entry queue follows, and the back divides x and y together
// in a restoring divider pipelined one quotient bit per stage (49 stages),
// then saturates into the output register, one pair per cycle when not
// stalled. Register 0 at address 0 holds fraction_bits (reset 16, values
// above 16 act as 16); write it only while the block is idle.
module line_intersection import li_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [1:0]            paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

`include "assert_macros.svh"

   logic [FRAC_WIDTH-1:0] frac_ff, frac_in;
   logic                  fw_valid, fw_ready, bq_valid, bq_ready;
   work_type              fw_data, bq_data;

   // configuration register
   assign pready = 1'b1;
   always_comb begin
      frac_in = frac_ff;
      if (psel && penable && pwrite && (paddr[1:1] == REG_FRACTION_BITS)) begin
         frac_in = pwdata[FRAC_WIDTH-1:0];
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         frac_ff <= FRAC_RESET;
      end else begin
         frac_ff <= frac_in;
      end
   end
   assign prdata = (paddr[1:1] == REG_FRACTION_BITS) ? 32'(frac_ff) : '0;

   li_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .frac_bits(frac_ff),
      .work_valid(fw_valid), .work_ready(fw_ready), .work_data(fw_data)
   );

   li_queue u_queue (
      .clock, .reset,
      .in_valid(fw_valid), .in_ready(fw_ready), .in_data(fw_data),
      .out_valid(bq_valid), .out_ready(bq_ready), .out_data(bq_data)
   );

   li_back u_back (
      .clock, .reset,
      .work_valid(bq_valid), .work_ready(bq_ready), .work_data(bq_data),
      .rsp_valid, .rsp_ready, .rsp_data
   );

   // a parallel result never flags overflow and carries a zero x coordinate
   `ASSERT_ALWAYS(a_par_clean, clock, reset,
      !rsp_valid || !rsp_data.parallel || (!rsp_data.overflow && rsp_data.cross_x == '0))
   // a stalled result holds until taken
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

endmodule

/* rtl/core/li_front.sv */
// ----------------------------------------------------------------------------
// li_front
// Accepts line pairs, forms products, determinant and numerators, classifies.
// Two registered stages with a valid/ready pipeline.
// ----------------------------------------------------------------------------
module li_front import li_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   input  logic [FRAC_WIDTH-1:0] frac_bits,
   output logic                  work_valid,
   input  logic                  work_ready,
   output work_type              work_data
);

   typedef struct packed {
      logic signed [PROD_WIDTH-1:0] p_a1b2;
      logic signed [PROD_WIDTH-1:0] p_a2b1;
      logic signed [PROD_WIDTH-1:0] p_b1c2;
      logic signed [PROD_WIDTH-1:0] p_b2c1;
      logic signed [PROD_WIDTH-1:0] p_c1a2;
      logic signed [PROD_WIDTH-1:0] p_c2a1;
      logic [FRAC_WIDTH-1:0]        frac;
   } prod_type;

   logic     s1_valid_ff, s1_valid_in;
   prod_type s1_ff, s1_in;
   logic     s2_valid_ff, s2_valid_in;
   work_type s2_ff, s2_in;
   logic     s1_adv, s2_adv;

   logic signed [DET_WIDTH-1:0] det, xn, yn;

   // pipeline advance: a stage moves when the one after it frees up
   assign s2_adv    = !s2_valid_ff || work_ready;
   assign s1_adv    = !s1_valid_ff || s2_adv;
   assign req_ready = s1_adv;

   // products
   always_comb begin
      s1_in.p_a1b2 = PROD_WIDTH'(req_data.line_a_x_coef * req_data.line_b_y_coef);
      s1_in.p_a2b1 = PROD_WIDTH'(req_data.line_b_x_coef * req_data.line_a_y_coef);
      s1_in.p_b1c2 = PROD_WIDTH'(req_data.line_a_y_coef * req_data.line_b_const);
      s1_in.p_b2c1 = PROD_WIDTH'(req_data.line_b_y_coef * req_data.line_a_const);
      s1_in.p_c1a2 = PROD_WIDTH'(req_data.line_a_const * req_data.line_b_x_coef);
      s1_in.p_c2a1 = PROD_WIDTH'(req_data.line_b_const * req_data.line_a_x_coef);
      s1_in.frac   = (frac_bits > FRAC_WIDTH'(FRAC_MAX)) ? FRAC_WIDTH'(FRAC_MAX) : frac_bits;
      s1_valid_in  = s1_adv ? req_valid : s1_valid_ff;
   end

   // differences, signs and magnitudes
   always_comb begin
      det = DET_WIDTH'(s1_ff.p_a1b2) - DET_WIDTH'(s1_ff.p_a2b1);
      xn  = DET_WIDTH'(s1_ff.p_b1c2) - DET_WIDTH'(s1_ff.p_b2c1);
      yn  = DET_WIDTH'(s1_ff.p_c1a2) - DET_WIDTH'(s1_ff.p_c2a1);
      s2_in.det_mag  = det[DET_WIDTH-1] ? MAG_WIDTH'(-det) : MAG_WIDTH'(det);
      s2_in.x_mag    = xn[DET_WIDTH-1]  ? MAG_WIDTH'(-xn)  : MAG_WIDTH'(xn);
      s2_in.y_mag    = yn[DET_WIDTH-1]  ? MAG_WIDTH'(-yn)  : MAG_WIDTH'(yn);
      s2_in.x_neg    = (xn != '0) && (xn[DET_WIDTH-1] != det[DET_WIDTH-1]);
      s2_in.y_neg    = (yn != '0) && (yn[DET_WIDTH-1] != det[DET_WIDTH-1]);
      s2_in.parallel = (det == '0);
      s2_in.frac     = s1_ff.frac;
      s2_valid_in    = s2_adv ? s1_valid_ff : s2_valid_ff;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s1_ff <= s1_in;
      end
      if (s2_adv) begin
         s2_ff <= s2_in;
      end
   end

   assign work_valid = s2_valid_ff;
   assign work_data  = s2_ff;

endmodule

/* rtl/core/li_queue.sv */
// ----------------------------------------------------------------------------
// li_queue
// Short FIFO between the front and the back.
// ----------------------------------------------------------------------------
module li_queue import li_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  work_type in_data,
   output logic     out_valid,
   input  logic     out_ready,
   output work_type out_data
);

   work_type              mem_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QPTR_WIDTH:0]   cnt_ff, cnt_in;
   logic                  push, pop;

   assign in_ready  = (cnt_ff != (QPTR_WIDTH+1)'(QUEUE_DEPTH));
   assign out_valid = (cnt_ff != '0);
   assign out_data  = mem_ff[rd_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // pointers and fill count
   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop  ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (QPTR_WIDTH+1)'(push) - (QPTR_WIDTH+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= in_data;
      end
   end

endmodule

/* rtl/core/li_back.sv */
// ----------------------------------------------------------------------------
// li_back
// Pipelined restoring divider: one quotient bit per stage for x and y,
// then saturation, sign and an output register.
// ----------------------------------------------------------------------------
module li_back import li_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     work_valid,
   output logic     work_ready,
   input  work_type work_data,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp_data
);

   localparam int NSTG = DIVD_WIDTH;
   localparam int REMW = MAG_WIDTH + 1;

   typedef struct packed {
      logic [DIVD_WIDTH-1:0] xd;   // dividend bits, shifted out from the top
      logic [DIVD_WIDTH-1:0] yd;
      logic [REMW-1:0]       xr;
      logic [REMW-1:0]       yr;
      logic [DIVD_WIDTH-1:0] xq;
      logic [DIVD_WIDTH-1:0] yq;
      logic [MAG_WIDTH-1:0]  dm;
      logic                  x_neg;
      logic                  y_neg;
      logic                  parallel;
   } div_type;

   div_type st_ff [NSTG+1];
   logic    vl_ff [NSTG+1];
   div_type st_in [NSTG+1];
   logic    adv   [NSTG+1];
   logic    out_valid_ff;
   rsp_type out_ff, out_in;
   logic    out_adv;

   logic [DIVD_WIDTH-1:0] xdiv, ydiv;

   assign out_adv = !out_valid_ff || rsp_ready;
   assign adv[NSTG] = !vl_ff[NSTG] || out_adv;
   assign work_ready = adv[0];

   // load dividend scaled by the fraction bits
   always_comb begin
      xdiv = DIVD_WIDTH'(work_data.x_mag) << work_data.frac;
      ydiv = DIVD_WIDTH'(work_data.y_mag) << work_data.frac;
      st_in[0].xd = xdiv;
      st_in[0].yd = ydiv;
      st_in[0].xr = '0;
      st_in[0].yr = '0;
      st_in[0].xq = '0;
      st_in[0].yq = '0;
      st_in[0].dm = work_data.parallel ? MAG_WIDTH'(1) : work_data.det_mag;
      st_in[0].x_neg = work_data.x_neg;
      st_in[0].y_neg = work_data.y_neg;
      st_in[0].parallel = work_data.parallel;
   end

   // one quotient bit per stage
   for (genvar g = 1; g <= NSTG; g++) begin : g_stage
      logic [REMW-1:0] xt, yt;
      assign adv[g-1] = !vl_ff[g-1] || adv[g];
      always_comb begin
         st_in[g] = st_ff[g-1];
         xt = {st_ff[g-1].xr[REMW-2:0], st_ff[g-1].xd[DIVD_WIDTH-1]};
         yt = {st_ff[g-1].yr[REMW-2:0], st_ff[g-1].yd[DIVD_WIDTH-1]};
         st_in[g].xd = st_ff[g-1].xd << 1;
         st_in[g].yd = st_ff[g-1].yd << 1;
         if (xt >= REMW'(st_ff[g-1].dm)) begin
            st_in[g].xr = xt - REMW'(st_ff[g-1].dm);
            st_in[g].xq = {st_ff[g-1].xq[DIVD_WIDTH-2:0], 1'b1};
         end else begin
            st_in[g].xr = xt;
            st_in[g].xq = {st_ff[g-1].xq[DIVD_WIDTH-2:0], 1'b0};
         end
         if (yt >= REMW'(st_ff[g-1].dm)) begin
            st_in[g].yr = yt - REMW'(st_ff[g-1].dm);
            st_in[g].yq = {st_ff[g-1].yq[DIVD_WIDTH-2:0], 1'b1};
         end else begin
            st_in[g].yr = yt;
            st_in[g].yq = {st_ff[g-1].yq[DIVD_WIDTH-2:0], 1'b0};
         end
      end
   end

   // stage registers
   for (genvar g = 0; g <= NSTG; g++) begin : g_reg
      always_ff @(posedge clock) begin
         if (reset) begin
            vl_ff[g] <= 1'b0;
         end else if (adv[g]) begin
            vl_ff[g] <= (g == 0) ? work_valid : vl_ff[g == 0 ? 0 : g-1];
         end
      end
      always_ff @(posedge clock) begin
         if (adv[g]) begin
            st_ff[g] <= st_in[g];
         end
      end
   end

   // saturate and apply sign
   always_comb begin
      logic [DIVD_WIDTH-1:0] cap, xl, yl, xs, ys;
      logic                  xo, yo;
      cap = DIVD_WIDTH'(1) << (RESULT_WIDTH - 1);
      xl = st_ff[NSTG].x_neg ? cap : cap - 1'b1;
      yl = st_ff[NSTG].y_neg ? cap : cap - 1'b1;
      xo = st_ff[NSTG].xq > xl;
      yo = st_ff[NSTG].yq > yl;
      xs = xo ? xl : st_ff[NSTG].xq;
      ys = yo ? yl : st_ff[NSTG].yq;
      xs = st_ff[NSTG].x_neg ? -xs : xs;
      ys = st_ff[NSTG].y_neg ? -ys : ys;
      if (st_ff[NSTG].parallel) begin
         out_in.cross_x  = '0;
         out_in.cross_y  = '0;
         out_in.parallel = 1'b1;
         out_in.overflow = 1'b0;
      end else begin
         out_in.cross_x  = xs[RESULT_WIDTH-1:0];
         out_in.cross_y  = ys[RESULT_WIDTH-1:0];
         out_in.parallel = 1'b0;
         out_in.overflow = xo || yo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_adv) begin
         out_valid_ff <= vl_ff[NSTG];
      end
   end

   always_ff @(posedge clock) begin
      if (out_adv) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

/* tb/tb_line_intersection.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_line_intersection
// Self-checking bench for the line intersection block: drives line pairs with
// random gaps, predicts each intersection point from its own exact divider
// model, and compares every returned transaction field by field.
// ----------------------------------------------------------------------------
module tb_line_intersection;
   import li_pkg::*;

   localparam int IDLE_PCT   = 18;
   localparam int LATENCY    = 80;
   localparam int STALL_LONG = 300;
   localparam int WDOG_LIMIT = 20000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [1:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   req_type pending_pairs[$];
   rsp_type expected_points[$];
   int      mismatch_count = 0;
   int      frac_setting = FRAC_MAX;
   int      hold_off = 0;
   bit      no_idle = 1'b0;
   int      quiet_cycles = 0;

   line_intersection u_top (.*);

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Exact truncated quotient num*2^fb/den, saturated to 32 bits.
   function automatic logic [32:0] fixed_divide(longint num, longint den, int fb);
      logic [127:0] nm, dm, q;
      bit neg, sat;
      logic [127:0] lim;
      nm  = (num < 0) ? -num : num;
      dm  = (den < 0) ? -den : den;
      neg = (num != 0) && ((num < 0) != (den < 0));
      q   = (nm << fb) / dm;
      lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
      sat = q > lim;
      if (sat) q = lim;
      if (neg) q = -q;
      return {sat, q[31:0]};
   endfunction

   function automatic rsp_type intersect_point(req_type p);
      longint a1, b1, c1, a2, b2, c2, det;
      logic [32:0] qx, qy;
      rsp_type r;
      int fb;
      a1 = p.line_a_x_coef; b1 = p.line_a_y_coef; c1 = p.line_a_const;
      a2 = p.line_b_x_coef; b2 = p.line_b_y_coef; c2 = p.line_b_const;
      fb  = (frac_setting > FRAC_MAX) ? FRAC_MAX : frac_setting;
      det = a1 * b2 - a2 * b1;
      r = '0;
      if (det == 0) begin
         r.parallel = 1'b1;
         return r;
      end
      qx = fixed_divide(b1 * c2 - b2 * c1, det, fb);
      qy = fixed_divide(c1 * a2 - c2 * a1, det, fb);
      r.cross_x  = qx[31:0];
      r.cross_y  = qy[31:0];
      r.overflow = qx[32] | qy[32];
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      mismatch_count++;
   endtask

   // Drive: present the next pending pair, idle at random.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_points.push_back(intersect_point(req_data));
            void'(pending_pairs.pop_front());
         end
         if (!req_valid || req_ready) begin
            if (pending_pairs.size() > (req_valid && req_ready ? 0 : 0) &&
                (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
               req_valid <= 1'b1;
               req_data  <= pending_pairs[0];
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: accept results, stall at random or for a long hold-off.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_points.size() == 0) begin
               report_mismatch("unexpected result", rsp_data.cross_x, 0);
            end else begin
               want = expected_points.pop_front();
               if (rsp_data.cross_x !== want.cross_x)
                  report_mismatch("cross_x", rsp_data.cross_x, want.cross_x);
               if (rsp_data.cross_y !== want.cross_y)
                  report_mismatch("cross_y", rsp_data.cross_y, want.cross_y);
               if (rsp_data.parallel !== want.parallel)
                  report_mismatch("parallel", rsp_data.parallel, want.parallel);
               if (rsp_data.overflow !== want.overflow)
                  report_mismatch("overflow", rsp_data.overflow, want.overflow);
            end
         end
         if (hold_off > 0) begin
            hold_off  <= hold_off - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // Watchdog: count cycles with no transaction on either channel.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WDOG_LIMIT) begin
         $display("[line_intersection] ERROR");
         $finish;
      end
   end

   task automatic write_frac(int value);
      @(posedge clock);
      psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
      paddr <= {REG_FRACTION_BITS, 1'b0}; pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      frac_setting = value & 31;
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_pairs.size() != 0 || req_valid || expected_points.size() != 0)
         @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   function automatic logic signed [15:0] pick_coef();
      case ($urandom_range(9))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return 16'sd0;
         3, 4: return $signed(16'($urandom_range(15))) - 16'sd8;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic req_type random_pair();
      req_type p;
      p.line_a_x_coef = pick_coef(); p.line_a_y_coef = pick_coef();
      p.line_a_const  = pick_coef(); p.line_b_x_coef = pick_coef();
      p.line_b_y_coef = pick_coef(); p.line_b_const  = pick_coef();
      // make a parallel pair now and then
      if ($urandom_range(9) == 0) begin
         p.line_b_x_coef = p.line_a_x_coef;
         p.line_b_y_coef = p.line_a_y_coef;
      end
      return p;
   endfunction

   task automatic load_random(int count);
      repeat (count) pending_pairs.push_back(random_pair());
   endtask

   initial begin
      int fracs[6] = '{0, 1, 8, 31, 20, 16};
      req_type p;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      // directed: extremes, parallel, coincident, zero numerator, saturation
      p = '{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000};
      pending_pairs.push_back(p);
      p = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff};
      pending_pairs.push_back(p);
      p = '{16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd0};
      pending_pairs.push_back(p);
      p = '{16'sd1, 16'sd1, 16'sd3, 16'sd2, 16'sd2, 16'sd6};
      pending_pairs.push_back(p);
      p = '{16'sd1, 16'sd1, 16'sd3, 16'sd1, 16'sd1, 16'sd5};
      pending_pairs.push_back(p);
      p = '{16'sd1, -16'sd1, 16'sh7fff, 16'sd1, 16'sd0, 16'sh8000};
      pending_pairs.push_back(p);
      p = '{16'sd1, 16'sd0, 16'sh8000, 16'sd0, 16'sd1, 16'sh7fff};
      pending_pairs.push_back(p);
      p = '{16'sd3, 16'sd7, -16'sd1, -16'sd5, 16'sd2, 16'sd1};
      pending_pairs.push_back(p);
      p = '{16'sh7fff, 16'sh7ffe, 16'sd0, 16'sh7ffe, 16'sh7ffd, 16'sd0};
      pending_pairs.push_back(p);
      // fill the block past its depth while the receiver holds off
      load_random(100);
      hold_off = STALL_LONG;
      wait_drained();
      // sweep fraction_bits across settings; calm run in the middle
      foreach (fracs[i]) begin
         write_frac(fracs[i]);
         no_idle = (i == 2);
         load_random(240);
         wait_drained();
      end
      no_idle = 1'b0;
      if (mismatch_count == 0)
         $display("[line_intersection] OK");
      else
         $display("[line_intersection] ERROR");
      $finish;
   end
endmodule
